FILE: rtl/assert_macros.svh
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define PMU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every rising edge, reset included.
`define PMU_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/pmu_pkg.sv
package pmu_pkg;

    localparam int DATA_W     = 32;
    localparam int GAIN_W     = 16;
    localparam int RAND_W     = 17;
    localparam int LIMIT_W    = 31;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int GAIN_FRAC  = 12;
    localparam int RAND_FRAC  = 16;
    localparam int PIPE_DEPTH = 7;

    typedef logic signed [DATA_W-1:0] q16_t;
    typedef logic [GAIN_W-1:0]        gain_t;
    typedef logic [RAND_W-1:0]        rand_t;
    typedef logic [LIMIT_W-1:0]       limit_t;
    typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0]    cfg_data_t;

    // Register map
    localparam cfg_idx_t REG_INERTIA_WEIGHT    = 3'd0;
    localparam cfg_idx_t REG_COGNITIVE_GAIN    = 3'd1;
    localparam cfg_idx_t REG_SOCIAL_GAIN       = 3'd2;
    localparam cfg_idx_t REG_VELOCITY_LIMIT    = 3'd3;
    localparam cfg_idx_t REG_VELOCITY_LIMIT_ON = 3'd4;
    localparam cfg_idx_t REG_POSITION_LIMIT    = 3'd5;
    localparam cfg_idx_t REG_POSITION_LIMIT_ON = 3'd6;

    // Reset values
    localparam gain_t  RST_INERTIA_WEIGHT = 16'd1638;
    localparam gain_t  RST_COGNITIVE_GAIN = 16'd8192;
    localparam gain_t  RST_SOCIAL_GAIN    = 16'd8192;
    localparam limit_t RST_VELOCITY_LIMIT = 31'd131072;
    localparam logic   RST_VELOCITY_ON    = 1'b1;
    localparam limit_t RST_POSITION_LIMIT = 31'd0;
    localparam logic   RST_POSITION_ON    = 1'b0;

endpackage

FILE: rtl/pmu_if.sv
interface pmu_item_if;
    logic               valid;
    logic               ready;
    pmu_pkg::q16_t      position;
    pmu_pkg::q16_t      velocity;
    pmu_pkg::q16_t      personal_best;
    pmu_pkg::q16_t      global_best;
    pmu_pkg::rand_t     rand_cognitive;
    pmu_pkg::rand_t     rand_social;
    logic               is_global_best;
    logic               last_element;

    modport source (
        output valid, position, velocity, personal_best, global_best,
        output rand_cognitive, rand_social, is_global_best, last_element,
        input  ready
    );
    modport sink (
        input  valid, position, velocity, personal_best, global_best,
        input  rand_cognitive, rand_social, is_global_best, last_element,
        output ready
    );
endinterface

interface pmu_result_if;
    logic               valid;
    logic               ready;
    pmu_pkg::q16_t      new_position;
    pmu_pkg::q16_t      new_velocity;
    logic               last_out;

    modport source (
        output valid, new_position, new_velocity, last_out,
        input  ready
    );
    modport sink (
        input  valid, new_position, new_velocity, last_out,
        output ready
    );
endinterface

interface pmu_cfg_if;
    logic                  valid;
    logic                  ready;
    pmu_pkg::cfg_idx_t     index;
    pmu_pkg::cfg_data_t    data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

FILE: rtl/pso_particle_move_unit.sv
// Particle swarm coordinate update, seven register stages.
// An accepted item word moves through the stage registers s1 to s7 in order to its result word.
// Throughput: one item word per cycle; each stage holds only while a full stage ahead stalls.
// Reset clears all stage valid bits and loads the default register values.
// Configuration writes are taken every cycle (ready held high).
module pso_particle_move_unit (
    input  logic                clk,
    input  logic                rst_n,
    pmu_cfg_if.sink             cfg,
    pmu_item_if.sink            item,
    pmu_result_if.source        result
);

    localparam int LAST = pmu_pkg::PIPE_DEPTH - 1;

    // Configuration registers
    pmu_pkg::gain_t  inertia_weight_reg;
    pmu_pkg::gain_t  cognitive_gain_reg;
    pmu_pkg::gain_t  social_gain_reg;
    pmu_pkg::limit_t velocity_limit_reg;
    logic            velocity_limit_on_reg;
    pmu_pkg::limit_t position_limit_reg;
    logic            position_limit_on_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inertia_weight_reg    <= pmu_pkg::RST_INERTIA_WEIGHT;
            cognitive_gain_reg    <= pmu_pkg::RST_COGNITIVE_GAIN;
            social_gain_reg       <= pmu_pkg::RST_SOCIAL_GAIN;
            velocity_limit_reg    <= pmu_pkg::RST_VELOCITY_LIMIT;
            velocity_limit_on_reg <= pmu_pkg::RST_VELOCITY_ON;
            position_limit_reg    <= pmu_pkg::RST_POSITION_LIMIT;
            position_limit_on_reg <= pmu_pkg::RST_POSITION_ON;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                pmu_pkg::REG_INERTIA_WEIGHT:    inertia_weight_reg    <= cfg.data[15:0];
                pmu_pkg::REG_COGNITIVE_GAIN:    cognitive_gain_reg    <= cfg.data[15:0];
                pmu_pkg::REG_SOCIAL_GAIN:       social_gain_reg       <= cfg.data[15:0];
                pmu_pkg::REG_VELOCITY_LIMIT:    velocity_limit_reg    <= cfg.data[30:0];
                pmu_pkg::REG_VELOCITY_LIMIT_ON: velocity_limit_on_reg <= cfg.data[0];
                pmu_pkg::REG_POSITION_LIMIT:    position_limit_reg    <= cfg.data[30:0];
                pmu_pkg::REG_POSITION_LIMIT_ON: position_limit_on_reg <= cfg.data[0];
                default: ;
            endcase
        end
    end

    // Saturate to 32 bits, or clamp to [-lim, +lim] when enabled.
    function automatic pmu_pkg::q16_t limit_value(
        input logic signed [39:0] x,
        input pmu_pkg::limit_t    lim,
        input logic               on
    );
        logic signed [39:0] hi;
        logic signed [39:0] lo;
        logic signed [39:0] r;
        hi = on ? $signed({9'b0, lim}) : 40'sh007FFFFFFF;
        lo = on ? -hi : 40'shFF80000000;
        if (x > hi)
            r = hi;
        else if (x < lo)
            r = lo;
        else
            r = x;
        return $signed(r[31:0]);
    endfunction

    // Stage handshake: a stage advances when empty or when the next one advances.
    logic [LAST:0] valid_reg;
    logic [LAST:0] advance;

    always_comb
    begin
        advance[LAST] = !valid_reg[LAST] || result.ready;
        for (int i = LAST - 1; i >= 0; i--)
            advance[i] = !valid_reg[i] || advance[i+1];
    end

    assign item.ready = advance[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (advance[0])
                valid_reg[0] <= item.valid;
            for (int i = 1; i <= LAST; i++)
                if (advance[i])
                    valid_reg[i] <= valid_reg[i-1];
        end
    end

    // Stage 1: differences to the best points
    pmu_pkg::q16_t      s1_pos_reg, s1_vel_reg;
    logic signed [32:0] s1_dc_reg, s1_ds_reg;
    logic signed [32:0] s1_dc_next, s1_ds_next;
    pmu_pkg::rand_t     s1_rc_reg, s1_rs_reg;
    logic               s1_best_reg, s1_last_reg;

    assign s1_dc_next = $signed({item.personal_best[31], item.personal_best})
                      - $signed({item.position[31], item.position});
    assign s1_ds_next = $signed({item.global_best[31], item.global_best})
                      - $signed({item.position[31], item.position});

    always_ff @(posedge clk)
    begin
        if (advance[0])
        begin
            s1_pos_reg  <= item.position;
            s1_vel_reg  <= item.velocity;
            s1_dc_reg   <= s1_dc_next;
            s1_ds_reg   <= s1_ds_next;
            s1_rc_reg   <= item.rand_cognitive;
            s1_rs_reg   <= item.rand_social;
            s1_best_reg <= item.is_global_best;
            s1_last_reg <= item.last_element;
        end
    end

    // Stage 2: gain products, floor by 2^12
    logic signed [47:0] inert_prod;
    logic signed [48:0] cogn_prod, soc_prod;
    pmu_pkg::q16_t      s2_pos_reg;
    logic signed [35:0] s2_inert_reg;
    logic signed [36:0] s2_ac_reg, s2_as_reg;
    pmu_pkg::rand_t     s2_rc_reg, s2_rs_reg;
    logic               s2_best_reg, s2_last_reg;

    assign inert_prod = s1_vel_reg * $signed({1'b0, inertia_weight_reg});
    assign cogn_prod  = s1_dc_reg * $signed({1'b0, cognitive_gain_reg});
    assign soc_prod   = s1_ds_reg * $signed({1'b0, social_gain_reg});

    always_ff @(posedge clk)
    begin
        if (advance[1])
        begin
            s2_pos_reg   <= s1_pos_reg;
            s2_inert_reg <= inert_prod[47:12];
            s2_ac_reg    <= cogn_prod[48:12];
            s2_as_reg    <= soc_prod[48:12];
            s2_rc_reg    <= s1_rc_reg;
            s2_rs_reg    <= s1_rs_reg;
            s2_best_reg  <= s1_best_reg;
            s2_last_reg  <= s1_last_reg;
        end
    end

    // Stage 3: random factor products, floor by 2^16
    logic signed [53:0] cogn_rprod, soc_rprod;
    pmu_pkg::q16_t      s3_pos_reg;
    logic signed [35:0] s3_inert_reg;
    logic signed [37:0] s3_cogn_reg, s3_soc_reg;
    logic               s3_last_reg;

    assign cogn_rprod = s2_ac_reg * $signed({1'b0, s2_rc_reg});
    assign soc_rprod  = s2_as_reg * $signed({1'b0, s2_rs_reg});

    always_ff @(posedge clk)
    begin
        if (advance[2])
        begin
            s3_pos_reg   <= s2_pos_reg;
            s3_inert_reg <= s2_inert_reg;
            s3_cogn_reg  <= cogn_rprod[53:16];
            // drop the social term for the swarm leader
            s3_soc_reg   <= s2_best_reg ? 38'sd0 : soc_rprod[53:16];
            s3_last_reg  <= s2_last_reg;
        end
    end

    // Stage 4: velocity sum
    logic signed [39:0] s4_sum_next;
    logic signed [39:0] s4_sum_reg;
    pmu_pkg::q16_t      s4_pos_reg;
    logic               s4_last_reg;

    assign s4_sum_next = {{4{s3_inert_reg[35]}}, s3_inert_reg}
                       + {{2{s3_cogn_reg[37]}}, s3_cogn_reg}
                       + {{2{s3_soc_reg[37]}}, s3_soc_reg};

    always_ff @(posedge clk)
    begin
        if (advance[3])
        begin
            s4_pos_reg  <= s3_pos_reg;
            s4_sum_reg  <= s4_sum_next;
            s4_last_reg <= s3_last_reg;
        end
    end

    // Stage 5: velocity saturate and clamp
    pmu_pkg::q16_t s5_vel_next;
    pmu_pkg::q16_t s5_vel_reg, s5_pos_reg;
    logic          s5_last_reg;

    assign s5_vel_next = limit_value(s4_sum_reg, velocity_limit_reg, velocity_limit_on_reg);

    always_ff @(posedge clk)
    begin
        if (advance[4])
        begin
            s5_pos_reg  <= s4_pos_reg;
            s5_vel_reg  <= s5_vel_next;
            s5_last_reg <= s4_last_reg;
        end
    end

    // Stage 6: position step
    logic signed [32:0] s6_psum_next;
    logic signed [32:0] s6_psum_reg;
    pmu_pkg::q16_t      s6_vel_reg;
    logic               s6_last_reg;

    assign s6_psum_next = $signed({s5_pos_reg[31], s5_pos_reg})
                        + $signed({s5_vel_reg[31], s5_vel_reg});

    always_ff @(posedge clk)
    begin
        if (advance[5])
        begin
            s6_psum_reg <= s6_psum_next;
            s6_vel_reg  <= s5_vel_reg;
            s6_last_reg <= s5_last_reg;
        end
    end

    // Stage 7: position saturate and clamp, output word
    pmu_pkg::q16_t s7_pos_next;
    pmu_pkg::q16_t s7_pos_reg, s7_vel_reg;
    logic          s7_last_reg;

    assign s7_pos_next = limit_value({{7{s6_psum_reg[32]}}, s6_psum_reg},
                                     position_limit_reg, position_limit_on_reg);

    always_ff @(posedge clk)
    begin
        if (advance[6])
        begin
            s7_pos_reg  <= s7_pos_next;
            s7_vel_reg  <= s6_vel_reg;
            s7_last_reg <= s6_last_reg;
        end
    end

    assign result.valid        = valid_reg[LAST];
    assign result.new_position = s7_pos_reg;
    assign result.new_velocity = s7_vel_reg;
    assign result.last_out     = s7_last_reg;

endmodule

FILE: rtl/pmu_checker.sv
`include "assert_macros.svh"

module pmu_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          item_ready,
    input logic          result_valid,
    input logic          result_ready,
    input pmu_pkg::q16_t result_position,
    input pmu_pkg::q16_t result_velocity,
    input logic          result_last
);

    // A stalled result word stays offered.
    `PMU_ASSERT(a_result_hold, clk, rst_n, result_valid && !result_ready |=> result_valid, "result word dropped while stalled")

    // A stalled result word keeps its payload.
    `PMU_ASSERT(a_result_stable, clk, rst_n, result_valid && !result_ready |=> $stable(result_position) && $stable(result_velocity) && $stable(result_last), "result payload changed while stalled")

    // The pipeline only refuses input when the output side is backed up.
    `PMU_ASSERT(a_ready_backpressure, clk, rst_n, !item_ready |-> result_valid && !result_ready, "input stalled without output backpressure")

    // Reset leaves no word in flight.
    `PMU_ASSERT_ALWAYS(a_reset_empty, clk, $past(!rst_n) |-> !result_valid, "result word offered right after reset")

endmodule

bind pso_particle_move_unit pmu_checker u_pmu_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_ready      (item.ready),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .result_position (result.new_position),
    .result_velocity (result.new_velocity),
    .result_last     (result.last_out)
);
